### hw/rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared widths, denomination reset values and chain beat types of the
// greedy change maker.
// ----------------------------------------------------------------------------
`default_nettype none

package gcm_pkg;

  localparam int unsigned NUM_DENOMS = 8;
  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned AMT_W      = 16;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned DIV_CNT_W  = $clog2(AMT_W);

  localparam logic [AMT_W-1:0] DENOM_RESET [SLOT_COUNT] = '{
    16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1, 16'd0, 16'd0
  };

  // remainder handed from one cell to the next
  typedef struct packed {
    logic             valid;
    logic [AMT_W-1:0] rem;
  } gcm_tok_t;

  // one paid denomination, from a cell to the collector
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] value;
    logic [AMT_W-1:0] count;
    logic [AMT_W-1:0] rem;
  } gcm_res_t;

endpackage

`default_nettype wire

### hw/rtl/gcm_if.sv
// ----------------------------------------------------------------------------
// gcm_if
// Valid/ready channels of the greedy change maker: amount in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcm_amount_if
  import gcm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [AMT_W-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink (input valid, input amount, output ready);
endinterface

interface gcm_result_if
  import gcm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] denom_index;
  logic [AMT_W-1:0] denom_value;
  logic [AMT_W-1:0] note_count;
  logic [AMT_W-1:0] remainder_left;
  logic             last;

  modport source (output valid, output denom_index, output denom_value,
                  output note_count, output remainder_left, output last,
                  input ready);
  modport sink (input valid, input denom_index, input denom_value,
                input note_count, input remainder_left, input last,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/gcm_cell.sv
// ----------------------------------------------------------------------------
// gcm_cell
// One denomination slot: bit-serial restoring divide of the incoming
// remainder, reports the paid count and hands the new remainder on.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_cell
  import gcm_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire logic [AMT_W-1:0] denom_i,
  input  wire gcm_tok_t        tok_i,
  output gcm_tok_t             tok_o,
  output gcm_res_t             res_o,
  input  wire                  res_ready_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_e;

  state_e               state_q;
  logic [AMT_W-1:0]     part_q;
  logic [AMT_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  gcm_tok_t             tok_q;

  logic [AMT_W:0]   shifted;
  logic             fits;
  logic [AMT_W:0]   diff;
  logic [AMT_W-1:0] part_d;
  logic [AMT_W-1:0] quo_d;
  logic             skip;

  always_comb begin
    shifted = {part_q, quo_q[AMT_W-1]};
    fits    = shifted >= {1'b0, denom_i};
    diff    = shifted - {1'b0, denom_i};
    part_d  = fits ? diff[AMT_W-1:0] : shifted[AMT_W-1:0];
    quo_d   = {quo_q[AMT_W-2:0], fits};
    skip    = (tok_i.rem == '0) || (denom_i == '0) || (denom_i > tok_i.rem);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tok_q     <= '0;
      part_q    <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
    end else begin
      tok_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (tok_i.valid) begin
            if (skip) begin
              tok_q.valid <= 1'b1;
              tok_q.rem   <= tok_i.rem;
            end else begin
              part_q  <= '0;
              quo_q   <= tok_i.rem;
              cnt_q   <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          part_q <= part_d;
          quo_q  <= quo_d;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(AMT_W - 1)) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (res_ready_i) begin
            tok_q.valid <= 1'b1;
            tok_q.rem   <= part_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign tok_o       = tok_q;
  assign res_o.valid = (state_q == S_HOLD);
  assign res_o.idx   = cell_idx_i;
  assign res_o.value = denom_i;
  assign res_o.count = quo_q;
  assign res_o.rem   = part_q;

endmodule

`default_nettype wire

### hw/rtl/gcm_collect.sv
// ----------------------------------------------------------------------------
// gcm_collect
// Holds back one paid result so the final one can be flagged last, and
// drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_collect
  import gcm_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire gcm_res_t     res_i,
  output logic              res_ready_o,
  input  wire gcm_tok_t     fin_i,
  output logic              done_o,
  gcm_result_if.source      result_if
);

  gcm_res_t         pend_q;
  logic             fin_q;
  logic [AMT_W-1:0] fin_rem_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [AMT_W-1:0] out_value_q;
  logic [AMT_W-1:0] out_count_q;
  logic [AMT_W-1:0] out_rem_q;
  logic             out_last_q;

  logic out_free;
  logic res_take;

  assign out_free    = !out_valid_q || result_if.ready;
  assign res_ready_o = !pend_q.valid || out_free;
  assign res_take    = res_i.valid && res_ready_o;
  assign done_o      = fin_q && out_free && !res_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      fin_q       <= 1'b0;
      fin_rem_q   <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_value_q <= '0;
      out_count_q <= '0;
      out_rem_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && result_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fin_i.valid) begin
        fin_q     <= 1'b1;
        fin_rem_q <= fin_i.rem;
      end
      if (res_take) begin
        if (pend_q.valid) begin
          out_valid_q <= 1'b1;
          out_idx_q   <= pend_q.idx;
          out_value_q <= pend_q.value;
          out_count_q <= pend_q.count;
          out_rem_q   <= pend_q.rem;
          out_last_q  <= 1'b0;
        end
        pend_q <= res_i;
      end else if (done_o) begin
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
        fin_q       <= 1'b0;
        pend_q.valid <= 1'b0;
        if (pend_q.valid) begin
          out_idx_q   <= pend_q.idx;
          out_value_q <= pend_q.value;
          out_count_q <= pend_q.count;
          out_rem_q   <= pend_q.rem;
        end else begin
          out_idx_q   <= '0;
          out_value_q <= '0;
          out_count_q <= '0;
          out_rem_q   <= fin_rem_q;
        end
      end
    end
  end

  assign result_if.valid          = out_valid_q;
  assign result_if.denom_index    = out_idx_q;
  assign result_if.denom_value    = out_value_q;
  assign result_if.note_count     = out_count_q;
  assign result_if.remainder_left = out_rem_q;
  assign result_if.last           = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/greedy_change_maker.sv
// ----------------------------------------------------------------------------
// greedy_change_maker
// Pays a change amount greedily out of up to eight configured denominations.
//
// amount_if takes one amount per beat; result_if returns one beat per paid
// denomination in slot order, the final one flagged last. If nothing can be
// paid, a single beat with index, value and count zero carries the amount.
// The denominations sit in a row of cells, one per slot; the remainder walks
// down the row. A cell that pays runs a bit-serial restoring divide; a skipped
// slot passes the remainder on unchanged. The next amount is taken once the
// last beat of the previous one has reached the output register.
// cfg_we_i writes denomination cfg_idx_i; write only while no amount is in
// flight. Reset loads 50, 20, 10, 5, 2, 1, 0, 0 and empties the row.
// A stalled result_if holds its beat; the row waits behind it and one pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_change_maker
  import gcm_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_idx_i,
  input  wire logic [AMT_W-1:0] cfg_data_i,
  gcm_amount_if.sink            amount_if,
  gcm_result_if.source          result_if
);

  logic             busy_q;
  logic [AMT_W-1:0] denom_q [NUM_DENOMS];
  gcm_tok_t         tok [NUM_DENOMS+1];
  gcm_res_t         res_c [NUM_DENOMS];
  gcm_res_t         res_all;
  logic             res_ready;
  logic             done;
  logic             in_take;

  assign amount_if.ready = !busy_q;
  assign in_take         = amount_if.valid && !busy_q;
  assign tok[0].valid    = in_take;
  assign tok[0].rem      = amount_if.amount;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_take) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_DENOMS; g++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        denom_q[g] <= DENOM_RESET[g];
      end else if (cfg_we_i && (cfg_idx_i == IDX_W'(g))) begin
        denom_q[g] <= cfg_data_i;
      end
    end

    gcm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDX_W'(g)),
      .denom_i     (denom_q[g]),
      .tok_i       (tok[g]),
      .tok_o       (tok[g+1]),
      .res_o       (res_c[g]),
      .res_ready_i (res_ready)
    );
  end

  // at most one cell holds a result at a time
  always_comb begin
    res_all = '0;
    for (int i = 0; i < NUM_DENOMS; i++) begin
      if (res_c[i].valid) begin
        res_all = res_c[i];
      end
    end
  end

  gcm_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_all),
    .res_ready_o (res_ready),
    .fin_i       (tok[NUM_DENOMS]),
    .done_o      (done),
    .result_if   (result_if)
  );

endmodule

`default_nettype wire

### sim/greedy_change_maker_tb.sv
// ----------------------------------------------------------------------------
// greedy_change_maker_tb
// Self-checking bench for the greedy change maker. Directed tests cover the
// reset denominations, a set that pays from every slot, sets that pay
// nothing, out-of-order and extreme sets. A random test then runs amounts
// through the reset set and then a series of random denomination sets. Each
// accepted amount is turned into its expected payout beats by a local greedy
// predictor; each result beat is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_change_maker_tb;
  import gcm_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned SETTLE_CYC   = 24;
  localparam int unsigned TAIL_CYC     = 160;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RAND_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS  = 30;

  typedef logic [AMT_W-1:0] denom_set_t [SLOT_COUNT];

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] value;
    logic [AMT_W-1:0] count;
    logic [AMT_W-1:0] rem;
    logic             last;
  } payout_t;

  typedef enum int {SET_DESC, SET_SMALL, SET_SPARSE, SET_UNORDERED} set_style_e;
  typedef enum int {RDY_ALWAYS, RDY_COMB, RDY_COIN, RDY_HOLD} ready_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [AMT_W-1:0] cfg_data;

  gcm_amount_if amt_ch ();
  gcm_result_if res_ch ();

  greedy_change_maker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .amount_if  (amt_ch),
    .result_if  (res_ch)
  );

  denom_set_t       denom_shadow;
  payout_t          payout_q [$];
  int unsigned      err_count;
  int unsigned      beat_count;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  ready_mode_e      rdy_mode;
  int unsigned      rdy_mode_left;
  int unsigned      rdy_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** greedy_change_maker: FAILED **");
      $finish;
    end
  end

  // greedy payout of one amount from the shadow denominations
  function automatic void make_change(input logic [AMT_W-1:0] amt);
    logic [AMT_W-1:0] rem;
    logic [AMT_W-1:0] d;
    payout_t          p;
    int               paid;
    rem  = amt;
    paid = 0;
    for (int s = 0; s < NUM_DENOMS && s < SLOT_COUNT; s++) begin
      if (rem == '0) break;
      d = denom_shadow[s];
      if (d == '0 || d > rem) continue;
      p.idx   = IDX_W'(s);
      p.value = d;
      p.count = rem / d;
      rem     = rem - p.count * d;
      p.rem   = rem;
      p.last  = 1'b0;
      payout_q.push_back(p);
      paid++;
    end
    if (paid == 0) begin
      p = '{idx: '0, value: '0, count: '0, rem: amt, last: 1'b1};
      payout_q.push_back(p);
    end else begin
      payout_q[payout_q.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("beat %0d: %s got %0d expected %0d", beat_count, field, got, want);
    err_count++;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    payout_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (payout_q.size() == 0) begin
          report_mismatch("unexpected beat, remainder", res_ch.remainder_left, 0);
        end else begin
          want = payout_q.pop_front();
          if (res_ch.denom_index !== want.idx)
            report_mismatch("denom_index", res_ch.denom_index, want.idx);
          if (res_ch.denom_value !== want.value)
            report_mismatch("denom_value", res_ch.denom_value, want.value);
          if (res_ch.note_count !== want.count)
            report_mismatch("note_count", res_ch.note_count, want.count);
          if (res_ch.remainder_left !== want.rem)
            report_mismatch("remainder_left", res_ch.remainder_left, want.rem);
          if (res_ch.last !== want.last)
            report_mismatch("last", res_ch.last, want.last);
        end
        beat_count++;
      end
      if (rdy_mode_left == 0) begin
        rdy_mode      = ready_mode_e'($urandom_range(0, 3));
        rdy_mode_left = $urandom_range(20, 200);
        rdy_hold_left = 0;
      end else begin
        rdy_mode_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: res_ch.ready <= 1'b1;
        RDY_COMB:   res_ch.ready <= (cycle_count % 4) != 0;
        RDY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rdy_hold_left > 0) begin
            rdy_hold_left--;
            res_ch.ready <= 1'b0;
          end else begin
            if ($urandom_range(0, 5) == 0) rdy_hold_left = $urandom_range(4, 20);
            res_ch.ready <= 1'b1;
          end
        end
      endcase
    end else begin
      res_ch.ready <= 1'b0;
    end
  end

  task automatic send_amount(input logic [AMT_W-1:0] amt);
    amt_ch.valid  <= 1'b1;
    amt_ch.amount <= amt;
    do @(posedge clk_i); while (!amt_ch.ready);
    make_change(amt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      amt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 6);
    end
  endtask

  task automatic drain();
    amt_ch.valid <= 1'b0;
    while (payout_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic load_denoms(input denom_set_t d);
    drain();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= IDX_W'(i);
      cfg_data <= d[i];
      @(posedge clk_i);
      denom_shadow[i] = d[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [AMT_W-1:0] pick_amount();
    logic [AMT_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return AMT_W'($urandom_range(0, 255));
      4, 5: begin
        d = denom_shadow[$urandom_range(0, SLOT_COUNT - 1)];
        return AMT_W'(d * $urandom_range(1, 8) + $urandom_range(0, 3));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return AMT_W'(1);
        endcase
      end
      default: return AMT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void make_denom_set(input set_style_e style, output denom_set_t d);
    logic [AMT_W-1:0] t;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      case (style)
        SET_SMALL: d[i] = AMT_W'($urandom_range(1, 40));
        SET_UNORDERED: d[i] = AMT_W'($urandom() >> $urandom_range(16, 31));
        default: d[i] = AMT_W'($urandom_range(1, 65535) >> $urandom_range(0, 15));
      endcase
    end
    if (style != SET_UNORDERED) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        for (int j = 0; j < SLOT_COUNT - 1 - i; j++)
          if (d[j] < d[j+1]) begin
            t      = d[j];
            d[j]   = d[j+1];
            d[j+1] = t;
          end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (style == SET_SPARSE && $urandom_range(0, 1) == 0) d[i] = '0;
      if (style == SET_DESC && $urandom_range(0, 5) == 0) d[i] = '0;
    end
    if (style == SET_SMALL && $urandom_range(0, 1) == 0) d[SLOT_COUNT-1] = AMT_W'(1);
  endfunction

  task automatic test_reset_defaults();
    send_amount(16'd0);
    send_amount(16'd1);
    send_amount(16'hFFFF);
    send_amount(16'd50);
    send_amount(16'd49);
    send_amount(16'd88);
    send_amount(16'd3);
  endtask

  task automatic test_all_slots();
    load_denoms('{16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1});
    send_amount(16'd255);
    send_amount(16'd256);
    send_amount(16'hFFFF);
  endtask

  task automatic test_nothing_paid();
    load_denoms('{default: 16'd0});
    send_amount(16'd0);
    send_amount(16'd12345);
    send_amount(16'hFFFF);
    load_denoms('{default: 16'hFFFF});
    send_amount(16'hFFFE);
  endtask

  task automatic test_out_of_order();
    load_denoms('{16'd3, 16'd7, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd9, 16'd2});
    send_amount(16'd20);
    send_amount(16'hFFFF);
    send_amount(16'd2);
    send_amount(16'd5);
  endtask

  task automatic test_extremes();
    load_denoms('{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
    send_amount(16'hFFFF);
    send_amount(16'hFFFE);
    send_amount(16'd0);
  endtask

  task automatic test_random_sets();
    denom_set_t d;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) d = DENOM_RESET;
      else make_denom_set(set_style_e'((ph - 1) % 4), d);
      load_denoms(d);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits out every outstanding beat mid-phase
        if (ph == 2 && n == PHASE_ITEMS / 2) drain();
        send_amount(pick_amount());
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    amt_ch.valid  <= 1'b0;
    amt_ch.amount <= '0;
    err_count     = 0;
    beat_count    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    rdy_mode      = RDY_ALWAYS;
    rdy_mode_left = 0;
    rdy_hold_left = 0;
    denom_shadow  = DENOM_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_all_slots();
    test_nothing_paid();
    test_out_of_order();
    test_extremes();
    test_random_sets();

    amt_ch.valid <= 1'b0;
    while (payout_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** greedy_change_maker: PASSED **");
    end else begin
      $display("** greedy_change_maker: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/gcm_pkg.sv
hw/rtl/gcm_if.sv
hw/rtl/gcm_cell.sv
hw/rtl/gcm_collect.sv
hw/rtl/greedy_change_maker.sv
sim/greedy_change_maker_tb.sv
